### rtl/tcu_pkg.sv
// Shared types and constants for the threshold centroid unit.
// Depends on nothing; used by every module of the block.
package tcu_pkg;

  localparam int PIX_W      = 8;
  localparam int THR_W      = 8;
  localparam int LW_W       = 13;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int SUM_W      = 36;
  localparam int TALLY_W    = 25;
  localparam int CTR_W      = 20;
  localparam int WRAP_W     = 18;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 72;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'd1;

  localparam logic [THR_W-1:0] THRESHOLD_RESET  = 8'h80;
  localparam logic [LW_W-1:0]  LINE_WIDTH_RESET = 13'd640;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accum;
    logic load;
    logic step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

### rtl/tcu_div.sv
// Restoring divider, one quotient bit per step, clamps at the centre range.
// Depends on tcu_pkg.
module tcu_div #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        step,
  input  logic [tcu_pkg::SUM_W-1:0]   sum,
  input  logic [tcu_pkg::TALLY_W-1:0] divisor,
  output logic [tcu_pkg::CTR_W-1:0]   quotient
);

  localparam int DVD_W = tcu_pkg::SUM_W + FRACTION_BITS;

  logic [DVD_W-1:0]            dvd;
  logic [tcu_pkg::TALLY_W-1:0] rem;
  logic [tcu_pkg::CTR_W-1:0]   quot;
  logic                        ovf;

  logic [tcu_pkg::TALLY_W:0]   trial;
  logic [tcu_pkg::TALLY_W:0]   diff;
  logic                        fits;
  logic [tcu_pkg::TALLY_W-1:0] rem_next;

  assign trial    = {rem, dvd[DVD_W-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign diff     = trial - {1'b0, divisor};
  assign rem_next = fits ? diff[tcu_pkg::TALLY_W-1:0] : trial[tcu_pkg::TALLY_W-1:0];

  always_ff @(posedge clk) begin
    if (load) begin
      dvd  <= DVD_W'(sum) << FRACTION_BITS;
      rem  <= '0;
      quot <= '0;
      ovf  <= 1'b0;
    end else if (step) begin
      dvd  <= {dvd[DVD_W-2:0], 1'b0};
      rem  <= rem_next;
      quot <= {quot[tcu_pkg::CTR_W-2:0], fits};
      ovf  <= ovf | quot[tcu_pkg::CTR_W-1];
    end
  end

  assign quotient = ovf ? '1 : quot;

endmodule

### rtl/tcu_ctrl.sv
// Controller state machine: accumulate, divide, hand over the result.
// Depends on tcu_pkg.
module tcu_ctrl #(
  parameter int FRACTION_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          s_tlast,
  output logic          s_tready,
  input  tcu_pkg::sts_t sts,
  output tcu_pkg::cmd_t cmd
);

  localparam int DIV_STEPS = tcu_pkg::SUM_W + FRACTION_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

  tcu_pkg::state_t state, state_next;
  logic [CNT_W-1:0] step_cnt, step_cnt_next;

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    case (state)
      tcu_pkg::ST_ACCUM: begin
        step_cnt_next = '0;
        if (s_tvalid && s_tlast) begin
          state_next = tcu_pkg::ST_DIVIDE;
        end
      end
      tcu_pkg::ST_DIVIDE: begin
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == LAST_STEP) begin
          state_next = tcu_pkg::ST_DONE;
        end
      end
      tcu_pkg::ST_DONE: begin
        if (sts.out_free) begin
          state_next = tcu_pkg::ST_ACCUM;
        end
      end
      default: begin
        state_next = tcu_pkg::ST_ACCUM;
      end
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    cmd         = '0;
    case (state)
      tcu_pkg::ST_ACCUM: begin
        s_tready  = 1'b1;
        cmd.accum = s_tvalid;
        cmd.load  = s_tvalid && s_tlast;
      end
      tcu_pkg::ST_DIVIDE: begin
        cmd.step = 1'b1;
      end
      tcu_pkg::ST_DONE: begin
        cmd.publish = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tcu_pkg::ST_ACCUM;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  a_load_starts_divide: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == tcu_pkg::ST_DIVIDE && step_cnt == '0)
    else $error("divide did not start after end of frame");

  a_divide_length: assert property (@(posedge clk) disable iff (rst)
    state == tcu_pkg::ST_DIVIDE && step_cnt == LAST_STEP |=> state == tcu_pkg::ST_DONE)
    else $error("divide ran past its last step");

  a_publish_then_accum: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> state == tcu_pkg::ST_ACCUM)
    else $error("controller did not return to accumulate");

endmodule

### rtl/tcu_dp.sv
// Datapath: configuration, raster position, saturating sums, dividers, output register.
// Depends on tcu_pkg and tcu_div.
module tcu_dp #(
  parameter int MAX_LINE      = 4096,
  parameter int MAX_ROWS      = 4096,
  parameter int FRACTION_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tcu_pkg::cmd_t                     cmd,
  output tcu_pkg::sts_t                     sts,
  input  logic [tcu_pkg::PIX_W-1:0]         pixel,
  input  logic                              end_of_frame,
  input  logic                              cfg_we,
  input  logic [tcu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcu_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              m_tready,
  output logic                              m_tvalid,
  output logic [tcu_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tuser
);

  localparam int COL_W = $clog2(MAX_LINE);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam logic [tcu_pkg::WRAP_W-1:0] LINE_LIMIT = tcu_pkg::WRAP_W'(MAX_LINE);
  localparam logic [ROW_W:0]             ROW_LIMIT  = (ROW_W + 1)'(MAX_ROWS);
  localparam int PAD_W = tcu_pkg::OUT_DATA_W - 2 * tcu_pkg::CTR_W - tcu_pkg::TALLY_W;

  logic [tcu_pkg::THR_W-1:0]   threshold;
  logic [tcu_pkg::LW_W-1:0]    line_width;
  logic [COL_W-1:0]            column;
  logic [ROW_W-1:0]            row;
  logic [tcu_pkg::SUM_W-1:0]   sum_columns, sum_columns_next;
  logic [tcu_pkg::SUM_W-1:0]   sum_rows, sum_rows_next;
  logic [tcu_pkg::TALLY_W-1:0] pixel_tally, pixel_tally_next;
  logic [tcu_pkg::TALLY_W-1:0] tally_hold;

  logic                        out_valid;
  logic [tcu_pkg::CTR_W-1:0]   out_x, out_y;
  logic [tcu_pkg::TALLY_W-1:0] out_count;
  logic                        out_empty;

  logic [tcu_pkg::WRAP_W-1:0]  width_ext, width_eff, col_inc;
  logic [ROW_W:0]              row_inc;
  logic                        bright;
  logic [tcu_pkg::SUM_W:0]     col_add, row_add;
  logic [tcu_pkg::CTR_W-1:0]   quot_x, quot_y;

  assign width_ext = tcu_pkg::WRAP_W'(line_width);
  assign width_eff = (line_width == '0) ? tcu_pkg::WRAP_W'(1) :
                     (width_ext > LINE_LIMIT) ? LINE_LIMIT : width_ext;
  assign col_inc   = tcu_pkg::WRAP_W'(column) + 1'b1;
  assign row_inc   = {1'b0, row} + 1'b1;

  assign bright  = pixel > threshold;
  assign col_add = {1'b0, sum_columns} + (tcu_pkg::SUM_W + 1)'(column);
  assign row_add = {1'b0, sum_rows} + (tcu_pkg::SUM_W + 1)'(row);

  always_comb begin
    sum_columns_next = sum_columns;
    sum_rows_next    = sum_rows;
    pixel_tally_next = pixel_tally;
    if (bright) begin
      sum_columns_next = col_add[tcu_pkg::SUM_W] ? '1 : col_add[tcu_pkg::SUM_W-1:0];
      sum_rows_next    = row_add[tcu_pkg::SUM_W] ? '1 : row_add[tcu_pkg::SUM_W-1:0];
      pixel_tally_next = (pixel_tally == '1) ? pixel_tally : pixel_tally + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= tcu_pkg::THRESHOLD_RESET;
      line_width <= tcu_pkg::LINE_WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tcu_pkg::REG_THRESHOLD:  threshold  <= cfg_data[tcu_pkg::THR_W-1:0];
        tcu_pkg::REG_LINE_WIDTH: line_width <= cfg_data[tcu_pkg::LW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column      <= '0;
      row         <= '0;
      sum_columns <= '0;
      sum_rows    <= '0;
      pixel_tally <= '0;
    end else if (cmd.accum) begin
      if (end_of_frame) begin
        column      <= '0;
        row         <= '0;
        sum_columns <= '0;
        sum_rows    <= '0;
        pixel_tally <= '0;
      end else begin
        sum_columns <= sum_columns_next;
        sum_rows    <= sum_rows_next;
        pixel_tally <= pixel_tally_next;
        if (col_inc >= width_eff) begin
          column <= '0;
          row    <= (row_inc >= ROW_LIMIT) ? '0 : row_inc[ROW_W-1:0];
        end else begin
          column <= col_inc[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tally_hold <= pixel_tally_next;
    end
  end

  tcu_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div_x (
    .clk      (clk),
    .load     (cmd.load),
    .step     (cmd.step),
    .sum      (sum_columns_next),
    .divisor  (tally_hold),
    .quotient (quot_x)
  );

  tcu_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div_y (
    .clk      (clk),
    .load     (cmd.load),
    .step     (cmd.step),
    .sum      (sum_rows_next),
    .divisor  (tally_hold),
    .quotient (quot_y)
  );

  assign sts.out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_empty <= tally_hold == '0;
      out_count <= tally_hold;
      out_x     <= (tally_hold == '0) ? '0 : quot_x;
      out_y     <= (tally_hold == '0) ? '0 : quot_y;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {PAD_W'(0), out_count, out_y, out_x};
  assign m_tuser  = out_empty;

  a_clear_after_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> pixel_tally == '0 && sum_columns == '0 && sum_rows == '0 && column == '0)
    else $error("frame state not cleared after end of frame");

  a_empty_reads_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_empty |-> out_x == '0 && out_y == '0 && out_count == '0)
    else $error("empty frame result carries non-zero fields");

  a_count_matches_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_empty |-> out_count != '0)
    else $error("non-empty result with zero count");

endmodule

### rtl/threshold_centroid_unit.sv
// Threshold centroid unit: one pixel per cycle within a frame; after the last pixel the
// two dividers divide the column and row sums by the bright-pixel count.
// Pixels stall while the dividers run, and longer if the previous result is not taken.
// Reset (rst, synchronous): clears position, sums and count; threshold 128, line width 640.
module threshold_centroid_unit #(
  parameter int MAX_LINE      = 4096,
  parameter int MAX_ROWS      = 4096,
  parameter int FRACTION_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [tcu_pkg::IN_DATA_W-1:0]      s_tdata,   // [7:0] pixel
  input  logic                               s_tlast,   // end_of_frame
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tcu_pkg::OUT_DATA_W-1:0]     m_tdata,   // [19:0] center_x, [39:20] center_y,
                                                        // [64:40] bright_count, rest zero
  output logic                               m_tuser,   // [0] empty_frame
  input  logic                               cfg_we,
  input  logic [tcu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcu_pkg::CFG_W-1:0]          cfg_data
);

  tcu_pkg::cmd_t cmd;
  tcu_pkg::sts_t sts;

  tcu_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcu_dp #(
    .MAX_LINE      (MAX_LINE),
    .MAX_ROWS      (MAX_ROWS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .pixel        (s_tdata[tcu_pkg::PIX_W-1:0]),
    .end_of_frame (s_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .m_tready     (m_tready),
    .m_tvalid     (m_tvalid),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for threshold_centroid_unit: raster frames in, centroids out.
// Needs tcu_pkg and the unit itself; predicts each frame's result and compares it.
module tb;

  localparam int MAX_LINE      = 4096;
  localparam int MAX_ROWS      = 4096;
  localparam int FRACTION_BITS = 8;
  localparam int RANDOM_PIXELS = 1700;
  localparam int DRAIN_CYCLES  = tcu_pkg::SUM_W + FRACTION_BITS + 16;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam logic [63:0] SUM_LIMIT    = (64'd1 << tcu_pkg::SUM_W) - 1;
  localparam logic [63:0] TALLY_LIMIT  = (64'd1 << tcu_pkg::TALLY_W) - 1;
  localparam logic [63:0] CENTRE_LIMIT = (64'd1 << tcu_pkg::CTR_W) - 1;

  typedef struct packed {
    logic [tcu_pkg::CTR_W-1:0]   center_x;
    logic [tcu_pkg::CTR_W-1:0]   center_y;
    logic [tcu_pkg::TALLY_W-1:0] bright_count;
    logic                        empty_frame;
  } centroid_t;

  typedef enum int {
    PIX_ANY,
    PIX_NEAR_LEVEL,
    PIX_DARK,
    PIX_BRIGHT,
    PIX_SPARSE
  } pix_mode_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [tcu_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [tcu_pkg::OUT_DATA_W-1:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 1'b0;
  logic [tcu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tcu_pkg::CFG_W-1:0] cfg_data = '0;

  // predictor state
  logic [tcu_pkg::THR_W-1:0]   threshold_q = tcu_pkg::THRESHOLD_RESET;
  logic [tcu_pkg::LW_W-1:0]    line_width_q = tcu_pkg::LINE_WIDTH_RESET;
  logic [11:0]                 col_pos = '0;
  logic [11:0]                 row_pos = '0;
  logic [tcu_pkg::SUM_W-1:0]   col_sum = '0;
  logic [tcu_pkg::SUM_W-1:0]   row_sum = '0;
  logic [tcu_pkg::TALLY_W-1:0] bright_tally = '0;
  centroid_t                   centroids_due[$];

  logic src_idle_on = 1'b1;
  logic sink_idle_on = 1'b1;
  int   hold_off_len = 0;
  int   pixels_sent = 0;
  int   frames_sent = 0;
  int   empty_frames = 0;
  int   reg_writes = 0;
  int   centroids_checked = 0;
  int   mismatches = 0;

  threshold_centroid_unit #(
    .MAX_LINE(MAX_LINE),
    .MAX_ROWS(MAX_ROWS),
    .FRACTION_BITS(FRACTION_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] limit);
    logic [63:0] s;
    s = a + b;
    return (s > limit) ? limit : s;
  endfunction

  function automatic logic [tcu_pkg::CTR_W-1:0] mean_pos(input logic [63:0] sum,
                                                         input logic [63:0] count);
    logic [63:0] q;
    if (count == 0) return '0;
    q = (sum << FRACTION_BITS) / count;
    return (q > CENTRE_LIMIT) ? CENTRE_LIMIT[tcu_pkg::CTR_W-1:0] : q[tcu_pkg::CTR_W-1:0];
  endfunction

  task automatic track_pixel(input logic [tcu_pkg::PIX_W-1:0] pix, input logic eof);
    logic [63:0] span;
    logic [63:0] acc;
    centroid_t res;
    if (line_width_q == 0) span = 64'd1;
    else if (line_width_q > MAX_LINE) span = 64'(MAX_LINE);
    else span = 64'(line_width_q);
    if (pix > threshold_q) begin
      acc = sat_add(64'(col_sum), 64'(col_pos), SUM_LIMIT);
      col_sum = acc[tcu_pkg::SUM_W-1:0];
      acc = sat_add(64'(row_sum), 64'(row_pos), SUM_LIMIT);
      row_sum = acc[tcu_pkg::SUM_W-1:0];
      acc = sat_add(64'(bright_tally), 64'd1, TALLY_LIMIT);
      bright_tally = acc[tcu_pkg::TALLY_W-1:0];
    end
    if (eof) begin
      res.center_x = mean_pos(64'(col_sum), 64'(bright_tally));
      res.center_y = mean_pos(64'(row_sum), 64'(bright_tally));
      res.bright_count = bright_tally;
      res.empty_frame = (bright_tally == 0);
      centroids_due.insert(centroids_due.size(), res);
      frames_sent++;
      if (res.empty_frame) empty_frames++;
      col_pos = '0;
      row_pos = '0;
      col_sum = '0;
      row_sum = '0;
      bright_tally = '0;
    end else if (64'(col_pos) + 1 >= span) begin
      col_pos = '0;
      row_pos = (64'(row_pos) + 1 >= MAX_ROWS) ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  task automatic send_pixel(input logic [tcu_pkg::PIX_W-1:0] pix, input logic eof);
    int gap;
    gap = src_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pix;
    s_tlast <= eof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pixels_sent++;
    track_pixel(pix, eof);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (centroids_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tcu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tcu_pkg::CFG_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      tcu_pkg::REG_THRESHOLD: threshold_q = value[tcu_pkg::THR_W-1:0];
      tcu_pkg::REG_LINE_WIDTH: line_width_q = value[tcu_pkg::LW_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [tcu_pkg::PIX_W-1:0] make_pixel(input pix_mode_t mode);
    int v;
    case (mode)
      PIX_NEAR_LEVEL: begin
        v = int'(threshold_q) + $urandom_range(0, 2) - 1;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[tcu_pkg::PIX_W-1:0];
      end
      PIX_DARK: return 8'($urandom_range(0, threshold_q));
      PIX_BRIGHT: return (threshold_q == 8'hFF) ? 8'hFF
                         : 8'($urandom_range(threshold_q + 1, 255));
      PIX_SPARSE: begin
        if ($urandom_range(0, 9) == 0 && threshold_q != 8'hFF)
          return 8'($urandom_range(threshold_q + 1, 255));
        return 8'($urandom_range(0, threshold_q));
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input int len, input pix_mode_t mode, input int split_at,
                            input logic [tcu_pkg::CFG_W-1:0] new_width);
    for (int i = 0; i < len; i++) begin
      if (i == split_at) write_reg(tcu_pkg::REG_LINE_WIDTH, new_width);
      send_pixel(make_pixel(mode), i == len - 1);
    end
  endtask

  // hold-off requests take priority over random stalls
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_len > 0) begin
        stall_left = hold_off_len;
        hold_off_len = 0;
      end else if (stall_left == 0 && sink_idle_on) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    centroid_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (centroids_due.size() == 0) begin
        $display("%0t unexpected centroid: x %0d y %0d count %0d empty %0b", $time,
                 m_tdata[19:0], m_tdata[39:20], m_tdata[64:40], m_tuser);
        mismatches++;
      end else begin
        want = centroids_due.pop_front();
        centroids_checked++;
        if (m_tdata[19:0] !== want.center_x) begin
          $display("%0t center_x: expected %0d, got %0d", $time, want.center_x, m_tdata[19:0]);
          mismatches++;
        end
        if (m_tdata[39:20] !== want.center_y) begin
          $display("%0t center_y: expected %0d, got %0d", $time, want.center_y, m_tdata[39:20]);
          mismatches++;
        end
        if (m_tdata[64:40] !== want.bright_count) begin
          $display("%0t bright_count: expected %0d, got %0d", $time, want.bright_count,
                   m_tdata[64:40]);
          mismatches++;
        end
        if (m_tuser !== want.empty_frame) begin
          $display("%0t empty_frame: expected %0b, got %0b", $time, want.empty_frame, m_tuser);
          mismatches++;
        end
        if (m_tdata[71:65] !== 7'd0) begin
          $display("%0t tdata padding: expected 0, got %0h", $time, m_tdata[71:65]);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d centroids still due", CYCLE_LIMIT,
             centroids_due.size());
    $display("TB_ERROR");
    $finish;
  end

  task automatic test_reset_values();
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd129, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b1);
  endtask

  task automatic test_threshold_extremes();
    write_reg(tcu_pkg::REG_THRESHOLD, 13'h1F00);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd1, 1'b1);
    write_reg(tcu_pkg::REG_THRESHOLD, 13'h00FF);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd254, 1'b1);
  endtask

  task automatic test_line_width_edges();
    write_reg(tcu_pkg::REG_THRESHOLD, 13'd0);
    write_reg(tcu_pkg::REG_LINE_WIDTH, 13'd0);
    send_frame(3, PIX_BRIGHT, -1, '0);
    write_reg(tcu_pkg::REG_LINE_WIDTH, 13'd5);
    send_frame(7, PIX_BRIGHT, 4, 13'd3);
  endtask

  task automatic test_output_backpressure();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    write_reg(tcu_pkg::REG_LINE_WIDTH, 13'd3);
    hold_off_len = 400;
    repeat (6) send_frame($urandom_range(2, 5), PIX_ANY, -1, '0);
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int sent_here;
    int frame_no;
    int len;
    int r;
    int split;
    logic [tcu_pkg::CFG_W-1:0] value;
    logic [tcu_pkg::CFG_W-1:0] new_width;
    sent_here = 0;
    frame_no = 0;
    while (sent_here < RANDOM_PIXELS) begin
      if (frame_no % 6 == 0) begin
        if ($urandom_range(0, 3) != 0)
          write_reg(tcu_pkg::REG_THRESHOLD, 13'($urandom_range(0, 8191)));
        r = $urandom_range(0, 99);
        if (r < 60) value = 13'($urandom_range(1, 16));
        else if (r < 70) value = 0;
        else if (r < 85) value = 13'($urandom_range(17, 700));
        else value = 13'($urandom_range(4090, 8191));
        write_reg(tcu_pkg::REG_LINE_WIDTH, value);
      end
      r = $urandom_range(0, 99);
      if (r < 85) len = $urandom_range(1, 24);
      else if (r < 97) len = $urandom_range(25, 120);
      else len = $urandom_range(121, 400);
      src_idle_on = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      split = -1;
      new_width = 13'($urandom_range(0, 16));
      if (len > 2 && $urandom_range(0, 9) == 0) split = $urandom_range(1, len - 1);
      send_frame(len, pix_mode_t'($urandom_range(0, 4)), split, new_width);
      sent_here += len;
      frame_no++;
    end
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  initial begin : run_tests
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_threshold_extremes();
    test_line_width_edges();
    test_output_backpressure();
    test_random_frames();
    drain();
    $display("Sent %0d pixels in %0d frames (%0d empty), %0d register writes.",
             pixels_sent, frames_sent, empty_frames, reg_writes);
    $display("Compared %0d centroids, %0d mismatches.", centroids_checked, mismatches);
    if (mismatches == 0 && centroids_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### threshold_centroid_unit.f
rtl/tcu_pkg.sv
rtl/tcu_div.sv
rtl/tcu_ctrl.sv
rtl/tcu_dp.sv
rtl/threshold_centroid_unit.sv
tb/tb.sv
